FILE: design/assert_macros.svh
// assertion macros shared by the deque rtl
// no dependencies; the SYNTH build gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled while reset is low
`define DEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion %m failed");
// next-cycle implication, disabled while reset is low
`define DEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion %m failed");
`else
`define DEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: design/deq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies
package deq_pkg;

  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  // stream payload widths; the tdata widths are padded to whole bytes
  localparam int IN_TDATA_W  = ((CMD_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + 1 + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 1 + STATUS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_UNDERFLOW = 2'd1,
    STS_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;        // run the accepted push, pop or empty dump
    logic dump_start;  // latch dump length, read the front slot
    logic dump_load;   // move the read word into the output register
    logic dump_next;   // step to the next slot and read it
  } deq_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_dump;     // incoming command decodes as a dump
    logic count_zero;
    logic out_free;    // output register can take an item this cycle
    logic elem_last;   // word in flight is the last one of the dump
  } deq_stat_t;

endpackage

FILE: design/deq_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/deq_datapath.sv
// deque datapath: head and count registers, slot ram, dump index, output register
// depends on deq_pkg, deq_ram and assert_macros.svh
`include "assert_macros.svh"

module deq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [deq_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  deq_pkg::deq_ctrl_t                  ctrl,
  output deq_pkg::deq_stat_t                  stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [deq_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                out_tlast
);

  import deq_pkg::*;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
    logic [IDX_W:0] t;
    t = (s >= (IDX_W+1)'(DEPTH)) ? s - (IDX_W+1)'(DEPTH) : s;
    return t[IDX_W-1:0];
  endfunction

  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] push_value;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;

  logic             full;
  logic [IDX_W-1:0] front_idx, rear_idx, head_inc, rd_addr;
  logic [IDX_W:0]   rd_off;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] rd_data;
  status_t          exec_status;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_ivalid_r, out_ivalid_nxt;
  logic                    out_last_r, out_last_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic                    out_empty_r, out_empty_nxt;

  assign cmd        = in_tdata[CMD_W-1:0];
  assign push_value = in_tdata[CMD_W +: VAL_W];

  assign full      = (count_r == CNT_W'(DEPTH));
  assign front_idx = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign rear_idx  = wrap_idx({1'b0, head_r} + {1'b0, count_r[IDX_W-1:0]});
  assign head_inc  = wrap_idx({1'b0, head_r} + (IDX_W+1)'(1));

  assign stat.is_dump    = !(cmd inside {CMD_PUSH_FRONT, CMD_PUSH_REAR,
                                         CMD_POP_FRONT, CMD_POP_REAR});
  assign stat.count_zero = (count_r == '0);
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.elem_last  = (CNT_W'(i_r + 1'b1) == n_r);

  // push, pop and empty-dump execution
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    wr_en       = 1'b0;
    wr_addr     = rear_idx;
    exec_status = STS_OK;
    if (ctrl.exec) begin
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (full) begin
            exec_status = STS_OVERFLOW;
          end else begin
            head_nxt  = front_idx;
            wr_en     = 1'b1;
            wr_addr   = front_idx;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_PUSH_REAR: begin
          if (full) begin
            exec_status = STS_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (stat.count_zero) begin
            exec_status = STS_UNDERFLOW;
          end else begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_POP_REAR: begin
          if (stat.count_zero) begin
            exec_status = STS_UNDERFLOW;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          // dump of an empty queue: one plain result
          exec_status = STS_OK;
        end
      endcase
    end
  end

  // dump walk: length capped at the result limit, one slot read per step
  always_comb begin
    n_nxt = n_r;
    i_nxt = i_r;
    if (ctrl.dump_start) begin
      n_nxt = (32'(count_r) > 32'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : count_r;
      i_nxt = '0;
    end else if (ctrl.dump_next) begin
      i_nxt = i_r + 1'b1;
    end
  end

  assign rd_off  = ctrl.dump_start ? '0 : (IDX_W+1)'(i_r + 1'b1);
  assign rd_addr = wrap_idx({1'b0, head_r} + rd_off);
  assign rd_en   = ctrl.dump_start || ctrl.dump_next;

  deq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_ivalid_nxt = out_ivalid_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;
    if (ctrl.exec) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = '0;
      out_ivalid_nxt = 1'b0;
      out_last_nxt   = 1'b1;
      out_status_nxt = exec_status;
      out_empty_nxt  = (count_nxt == '0);
    end else if (ctrl.dump_load) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = rd_data;
      out_ivalid_nxt = 1'b1;
      out_last_nxt   = stat.elem_last;
      out_status_nxt = STS_OK;
      out_empty_nxt  = stat.count_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    out_value_r  <= out_value_nxt;
    out_ivalid_r <= out_ivalid_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_empty_r, out_value_r});
  assign out_tuser  = {out_status_r, out_ivalid_r};
  assign out_tlast  = out_last_r;

  `DEQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `DEQ_ASSERT_IMP(a_rw_exclusive, clk, rst_n, wr_en, !rd_en)
  `DEQ_ASSERT_NXT(a_push_grows, clk, rst_n, wr_en, count_r == CNT_W'($past(count_r) + 1'b1))

endmodule

FILE: design/deq_ctrl.sv
// deque controller: idle / dump state machine driving the datapath
// depends on deq_pkg and assert_macros.svh
`include "assert_macros.svh"

module deq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_ctrl_t ctrl
);

  import deq_pkg::*;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (stat.is_dump && !stat.count_zero) begin
            ctrl.dump_start = 1'b1;
            state_nxt       = S_DUMP;
          end else begin
            ctrl.exec = 1'b1;
          end
        end
      end
      S_DUMP: begin
        // one stored word per free output slot
        if (stat.out_free) begin
          ctrl.dump_load = 1'b1;
          if (stat.elem_last) begin
            state_nxt = S_IDLE;
          end else begin
            ctrl.dump_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `DEQ_ASSERT_NXT(a_dump_enter, clk, rst_n, ctrl.dump_start, state_r == S_DUMP)
  `DEQ_ASSERT_IMP(a_load_free, clk, rst_n, ctrl.exec || ctrl.dump_load, stat.out_free)
  `DEQ_ASSERT_IMP(a_dump_blocks, clk, rst_n, state_r == S_DUMP, !in_tready)

endmodule

FILE: design/double_ended_queue.sv
// double-ended queue top level: controller plus datapath
// depends on deq_pkg, deq_ctrl and deq_datapath
//
// usage:
//   in_*  channel takes one command per item: cmd selects push front, push
//         rear, pop front, pop rear or dump; push_value is stored by pushes.
//   out_* channel returns results. push, pop and an empty dump give one item
//         with tlast high; a dump of N stored words gives min(N, 32) items,
//         front to rear, tlast on the final one. codes 5 to 7 act as a dump.
//   push and pop: the result is registered and shows in the cycle after the
//   command is taken; one command per cycle while the output drains.
//   dump: the first word passes the registered slot ram read, then the output
//   register; after that one word per cycle while the output drains; input
//   is held off until the last word has entered the output register.
//   reset: empty queue, head at slot zero, no result pending; slot contents
//   are not cleared.
//   a stall on out_tready holds the output register and, through it, the
//   input side and the dump walk; nothing is lost or repeated.
module double_ended_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] cmd, [34:3] push_value, rest zero
  input  logic [deq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] item_value, [32] is_empty, rest zero
  output logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] item_valid, [2:1] status
  output logic [deq_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast
);

  import deq_pkg::*;

  deq_ctrl_t ctrl;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  deq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: verif/tb_double_ended_queue.sv
// self-checking bench for double_ended_queue: directed corner items, then biased random
// fill/drain traffic with random stalls on both stream sides; depends on deq_pkg and the rtl
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 320;
  localparam int TAIL_ITEMS   = 60;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {
    SEG_MIXED,
    SEG_FILL,
    SEG_DRAIN,
    SEG_TO_FULL,
    SEG_TO_EMPTY
  } seg_kind_t;

  typedef struct {
    logic [VAL_W-1:0] item_value;
    logic             item_valid;
    logic             last_result;
    status_t          status;
    logic             is_empty;
  } deq_result_t;

  // mirror of the ring buffer plus the results it owes
  class deque_mirror;
    logic [VAL_W-1:0] slots [DEPTH];
    int unsigned      head;
    int unsigned      count;
    deq_result_t      awaited [$];
    int unsigned      mismatches;

    function new();
      head = 0;
      count = 0;
      mismatches = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int unsigned occupancy();
      return count;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function void owe(logic [VAL_W-1:0] value, logic valid, logic last, status_t sts);
      deq_result_t r;
      r.item_value  = value;
      r.item_valid  = valid;
      r.last_result = last;
      r.status      = sts;
      r.is_empty    = (count == 0);
      awaited.push_back(r);
    endfunction

    function void take_command(logic [CMD_W-1:0] code, logic [VAL_W-1:0] value);
      status_t     sts;
      int unsigned n;
      sts = STS_OK;
      case (code)
        CMD_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            sts = STS_OVERFLOW;
          end else begin
            head = (head == 0) ? DEPTH - 1 : head - 1;
            slots[head] = value;
            count++;
          end
        end
        CMD_PUSH_REAR: begin
          if (count >= DEPTH) begin
            sts = STS_OVERFLOW;
          end else begin
            slots[(head + count) % DEPTH] = value;
            count++;
          end
        end
        CMD_POP_FRONT: begin
          if (count == 0) begin
            sts = STS_UNDERFLOW;
          end else begin
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        CMD_POP_REAR: begin
          if (count == 0) sts = STS_UNDERFLOW;
          else count--;
        end
        // dump, and the unused codes behave the same
        default: begin
          if (count == 0) begin
            owe('0, 1'b0, 1'b1, STS_OK);
          end else begin
            n = (count > MAX_RESULTS) ? MAX_RESULTS : count;
            for (int unsigned i = 0; i < n; i++)
              owe(slots[(head + i) % DEPTH], 1'b1, (i + 1 == n), STS_OK);
          end
          return;
        end
      endcase
      owe('0, 1'b0, 1'b1, sts);
    endfunction

    function void compare(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        $error("%s expected %h got %h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser,
                               logic tlast);
      deq_result_t want;
      if (awaited.size() == 0) begin
        $error("result item with no expectation waiting: tdata %h tuser %h", tdata, tuser);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare("item_value", want.item_value, tdata[VAL_W-1:0]);
      compare("is_empty", want.is_empty, tdata[VAL_W]);
      compare("item_valid", want.item_valid, tuser[0]);
      compare("status", want.status, tuser[2:1]);
      compare("last_result", want.last_result, tlast);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  deque_mirror mirror       = new();
  bit          quiet_tail   = 1'b0;
  int unsigned gap_pct      = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;

  double_ended_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: long ready stretches broken by stall bursts
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      mirror.check_result(out_tdata, out_tuser, out_tlast);
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("double_ended_queue verification failed");
        $finish;
      end
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] code, logic [VAL_W-1:0] value);
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tdata  <= {{(IN_TDATA_W - CMD_W - VAL_W){1'b0}}, value, code};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.take_command(code, value);
    items_sent++;
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_push();
    send_cmd($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, random_value());
  endtask

  task automatic send_pop();
    send_cmd($urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT, $urandom());
  endtask

  task automatic send_mixed(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) send_cmd(CMD_DUMP, $urandom());
    else if (r < 8) send_cmd(CMD_W'($urandom_range(5, 7)), $urandom());
    else if ($urandom_range(0, 99) < push_pct) send_push();
    else send_pop();
  endtask

  task automatic run_directed();
    gap_pct = 30;
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_REAR, 32'hffff_ffff);
    send_cmd(CMD_DUMP, 32'h0);
    send_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_cmd(CMD_PUSH_REAR, 32'h8000_0000);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
    send_cmd(CMD_PUSH_REAR, 32'hffff_ffff);
    send_cmd(CMD_DUMP, 32'h5555_5555);
    send_cmd(3'd5, 32'haaaa_aaaa);
    send_cmd(CMD_POP_FRONT, 32'h1234_5678);
    send_cmd(CMD_POP_REAR, 32'h0);
    send_cmd(3'd6, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_REAR, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(3'd7, 32'hffff_ffff);
    send_cmd(CMD_PUSH_REAR, 32'h0000_0001);
    send_cmd(CMD_DUMP, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
  endtask

  task automatic run_random();
    seg_kind_t   kind;
    int unsigned seg_len;
    int unsigned start;
    start = items_sent;
    kind = SEG_TO_FULL;
    while (items_sent - start < RANDOM_ITEMS) begin
      quiet_tail = (items_sent - start >= RANDOM_ITEMS - TAIL_ITEMS);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 50;
      endcase
      seg_len = $urandom_range(8, 48);
      case (kind)
        SEG_TO_FULL: begin
          // fill up, push past the top, then read it all back
          while (mirror.occupancy() < DEPTH) send_push();
          repeat ($urandom_range(1, 3)) send_push();
          send_cmd(CMD_DUMP, $urandom());
        end
        SEG_TO_EMPTY: begin
          while (mirror.occupancy() > 0) send_pop();
          repeat ($urandom_range(1, 2)) send_pop();
          send_cmd(CMD_DUMP, $urandom());
        end
        SEG_FILL:  repeat (seg_len) send_mixed(80);
        SEG_DRAIN: repeat (seg_len) send_mixed(20);
        default:   repeat (seg_len) send_mixed(50);
      endcase
      kind = seg_kind_t'($urandom_range(SEG_MIXED, SEG_TO_EMPTY));
    end
    quiet_tail = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/deq_pkg.sv
design/deq_ram.sv
design/deq_datapath.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
verif/tb_double_ended_queue.sv
